[src/ils_pkg.sv]
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and codes for the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

   localparam int DepthDefault     = 64;
   localparam int ElemWidthDefault = 32;

   localparam int ModeWidth   = 3;
   localparam int PosWidth    = 7;
   localparam int ValueWidth  = 32;
   localparam int StrideWidth = 7;
   localparam int DataWidth   = 32;
   localparam int FoundWidth  = 6;
   localparam int CountWidth  = 7;
   localparam int StatusWidth = 3;

   typedef enum logic [ModeWidth-1:0] {
      MODE_READ      = 3'd0,
      MODE_OVERWRITE = 3'd1,
      MODE_INSERT    = 3'd2,
      MODE_DELETE    = 3'd3,
      MODE_APPEND    = 3'd4,
      MODE_SEARCH    = 3'd5,
      MODE_REMOVE    = 3'd6,
      MODE_NOP       = 3'd7
   } mode_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK         = 3'd0,
      ST_BADPOS     = 3'd1,
      ST_ZEROSTRIDE = 3'd2,
      ST_FULL       = 3'd3,
      ST_NOTFOUND   = 3'd4
   } status_type;

   // what every cell does this cycle
   typedef enum logic [2:0] {
      CELL_HOLD  = 3'd0,
      CELL_WRITE = 3'd1,   // take the broadcast value if selected
      CELL_UP    = 3'd2,   // take left neighbor if at or above position
      CELL_DOWN  = 3'd3,   // take right neighbor if at or above position
      CELL_PACK  = 3'd4    // stride compaction step
   } cell_op_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_PACK,
      FSM_DONE
   } fsm_type;

endpackage

[src/ils_cell.sv]
// ----------------------------------------------------------------------------
// ils_cell
// One list slot: holds an element and flags whether it matches the bus value.
// ----------------------------------------------------------------------------
module ils_cell
   import ils_pkg::*;
#(
   parameter int ELEM_WIDTH = ElemWidthDefault
) (
   input  logic                  clock,
   input  cell_op_type           op,
   input  logic                  sel,       // write target or shift boundary hit
   input  logic [ELEM_WIDTH-1:0] bus_value,
   input  logic [ELEM_WIDTH-1:0] left_value,
   input  logic [ELEM_WIDTH-1:0] right_value,
   output logic [ELEM_WIDTH-1:0] value,
   output logic                  match
);

   logic [ELEM_WIDTH-1:0] value_ff, value_in;

   always_comb begin
      value_in = value_ff;
      case (op)
         CELL_WRITE: if (sel) value_in = bus_value;
         CELL_UP:    if (sel) value_in = left_value;
         CELL_DOWN:  if (sel) value_in = right_value;
         CELL_PACK: begin
            // a removed slot sits at the cursor, pull the right neighbor down
            if (sel) value_in = right_value;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign match = (value_ff == bus_value);

endmodule

[src/indexed_list_store_core.sv]
// ----------------------------------------------------------------------------
// indexed_list_store_core
// Positional list store built as a row of element cells.
// ----------------------------------------------------------------------------
// A request is registered at its accepting edge, the cell row does one
// parallel step in the next cycle, and the response is held in the cycle
// after that until it transfers; no new request is taken before then.
// Remove every k-th walks a cursor over the row from the front, counting
// the stride phase and squeezing out one doomed slot per cycle.
// Search finds the lowest matching slot through a priority pick over the
// row's match flags. Entries are never read above the element count.
module indexed_list_store_core
   import ils_pkg::*;
#(
   parameter int DEPTH      = DepthDefault,
   parameter int ELEM_WIDTH = ElemWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[2:0], position[9:3], value[41:10], stride[48:42], zero fill
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // data[31:0], found_index[37:32], removed_count[44:38], size[51:45],
   // status[54:52], zero fill
   output logic [55:0] rsp_tdata
);

   localparam int IdxW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   fsm_type state_ff, state_in;

   mode_type              mode_ff;
   logic [PosWidth-1:0]   pos_ff;
   logic [ELEM_WIDTH-1:0] val_ff;
   logic [StrideWidth-1:0] k_ff;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic [IdxW:0]         scan_ff, scan_in;
   logic [CntW-1:0]       rem_ff, rem_in;
   logic [StrideWidth-1:0] phase_ff, phase_in;

   logic [DataWidth-1:0]   o_data_ff, o_data_in;
   logic [FoundWidth-1:0]  o_found_ff, o_found_in;
   logic [CountWidth-1:0]  o_rem_ff, o_rem_in;
   logic [StatusWidth-1:0] o_st_ff, o_st_in;

   cell_op_type           op;
   logic [DEPTH-1:0]      sel, match;
   logic [ELEM_WIDTH-1:0] cval [DEPTH];

   logic [CntW-1:0]  cnt_pos;
   logic             pos_lt, pos_le, full, in_accept;
   logic [IdxW-1:0]  first_idx;
   logic             any_match;

   assign in_accept = req_tvalid && req_tready;
   assign cnt_pos   = CntW'(pos_ff);
   assign pos_lt    = (PosWidth'(cnt_ff) > pos_ff) && (pos_ff < PosWidth'(DEPTH));
   assign pos_le    = (PosWidth'(cnt_ff) >= pos_ff);
   assign full      = (cnt_ff == CntW'(DEPTH));

   always_comb begin
      any_match = 1'b0;
      first_idx = '0;
      for (int j = DEPTH - 1; j >= 0; j--) begin
         if (match[j] && (CntW'(j) < cnt_ff)) begin
            any_match = 1'b1;
            first_idx = IdxW'(j);
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic [ELEM_WIDTH-1:0] lv, rv;
         if (g == 0) begin : g_l
            assign lv = val_ff;
         end else begin : g_l
            // the slot at the insert position takes the new element
            assign lv = (pos_ff == PosWidth'(g)) ? val_ff : cval[g-1];
         end
         if (g == DEPTH - 1) begin : g_r
            assign rv = cval[g];
         end else begin : g_r
            assign rv = cval[g+1];
         end
         ils_cell #(.ELEM_WIDTH(ELEM_WIDTH)) u_cell (
            .clock      (clock),
            .op         (op),
            .sel        (sel[g]),
            .bus_value  (val_ff),
            .left_value (lv),
            .right_value(rv),
            .value      (cval[g]),
            .match      (match[g])
         );
      end
   endgenerate

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: if (in_accept) state_in = FSM_EXEC;
         FSM_EXEC: begin
            if (mode_ff == MODE_REMOVE && k_ff != '0 && cnt_ff >= CntW'(k_ff))
               state_in = FSM_PACK;
            else
               state_in = FSM_DONE;
         end
         FSM_PACK: if (scan_ff >= (IdxW+1)'(cnt_ff)) state_in = FSM_DONE;
         FSM_DONE: if (rsp_tready) state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   // datapath control and result
   always_comb begin
      op         = CELL_HOLD;
      sel        = '0;
      cnt_in     = cnt_ff;
      scan_in    = scan_ff;
      rem_in     = rem_ff;
      phase_in   = phase_ff;
      o_data_in  = o_data_ff;
      o_found_in = o_found_ff;
      o_rem_in   = o_rem_ff;
      o_st_in    = o_st_ff;
      case (state_ff)
         FSM_EXEC: begin
            o_data_in  = '0;
            o_found_in = '0;
            o_rem_in   = '0;
            o_st_in    = ST_OK;
            scan_in    = '0;
            rem_in     = '0;
            phase_in   = StrideWidth'(1);
            case (mode_ff)
               MODE_READ: begin
                  if (!pos_lt) o_st_in = ST_BADPOS;
                  else o_data_in = DataWidth'(cval[pos_ff[IdxW-1:0]]);
               end
               MODE_OVERWRITE: begin
                  if (!pos_lt) o_st_in = ST_BADPOS;
                  else begin
                     o_data_in = DataWidth'(cval[pos_ff[IdxW-1:0]]);
                     op = CELL_WRITE;
                     sel[pos_ff[IdxW-1:0]] = 1'b1;
                  end
               end
               MODE_INSERT: begin
                  if (!pos_le) o_st_in = ST_BADPOS;
                  else if (full) o_st_in = ST_FULL;
                  else begin
                     op = CELL_UP;
                     for (int j = 0; j < DEPTH; j++)
                        sel[j] = (CntW'(j) >= cnt_pos) && (CntW'(j) <= cnt_ff);
                     cnt_in = cnt_ff + CntW'(1);
                  end
               end
               MODE_DELETE: begin
                  if (!pos_lt) o_st_in = ST_BADPOS;
                  else begin
                     o_data_in = DataWidth'(cval[pos_ff[IdxW-1:0]]);
                     op = CELL_DOWN;
                     for (int j = 0; j < DEPTH; j++)
                        sel[j] = (CntW'(j) >= cnt_pos);
                     cnt_in = cnt_ff - CntW'(1);
                  end
               end
               MODE_APPEND: begin
                  if (full) o_st_in = ST_FULL;
                  else begin
                     op = CELL_WRITE;
                     sel[cnt_ff[IdxW-1:0]] = 1'b1;
                     cnt_in = cnt_ff + CntW'(1);
                  end
               end
               MODE_SEARCH: begin
                  if (!any_match) o_st_in = ST_NOTFOUND;
                  else o_found_in = FoundWidth'(first_idx);
               end
               MODE_REMOVE: begin
                  if (k_ff == '0) o_st_in = ST_ZEROSTRIDE;
               end
               default: ;
            endcase
         end
         FSM_PACK: begin
            // walk a cursor; the element at the k-th phase is squeezed out
            if (scan_ff < (IdxW+1)'(cnt_ff)) begin
               if (phase_ff == k_ff) begin
                  op = CELL_PACK;
                  for (int j = 0; j < DEPTH; j++)
                     sel[j] = ((IdxW+1)'(j) >= scan_ff);
                  cnt_in   = cnt_ff - CntW'(1);
                  rem_in   = rem_ff + CntW'(1);
                  phase_in = StrideWidth'(1);
               end else begin
                  scan_in  = scan_ff + (IdxW+1)'(1);
                  phase_in = phase_ff + StrideWidth'(1);
               end
            end else begin
               o_rem_in = CountWidth'(rem_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         mode_ff <= mode_type'(req_tdata[2:0]);
         pos_ff  <= req_tdata[9:3];
         val_ff  <= ELEM_WIDTH'(req_tdata[41:10]);
         k_ff    <= req_tdata[48:42];
      end
      scan_ff    <= scan_in;
      rem_ff     <= rem_in;
      phase_ff   <= phase_in;
      o_data_ff  <= o_data_in;
      o_found_ff <= o_found_in;
      o_rem_ff   <= o_rem_in;
      o_st_ff    <= o_st_in;
   end

   assign req_tready = (state_ff == FSM_IDLE);
   assign rsp_tvalid = (state_ff == FSM_DONE);
   assign rsp_tdata  = {1'b0, o_st_ff, CountWidth'(cnt_ff), o_rem_ff, o_found_ff, o_data_ff};

endmodule
